[sv/ptq_pkg.sv]
// Shared types and constants of the pulse tachometer qualifier.
// Holds the register file layout, the controller/datapath command bundle and field widths.
// No dependencies.
package ptq_pkg;

  // Default sizes of the timers and event counters.
  localparam int unsigned TimeWidthDef  = 26;
  localparam int unsigned CountWidthDef = 16;

  // Widths of the output fields.
  localparam int unsigned RpmW    = 26;
  localparam int unsigned FiltW   = 24;
  localparam int unsigned PeriodW = 26;
  localparam int unsigned CountW  = 16;

  // Stream data widths.
  localparam int unsigned STdataW = 8;
  localparam int unsigned MTdataW = 128;

  // Quotient of the rpm division and its numerator.
  localparam int unsigned QuotW      = 26;
  localparam int unsigned DivCntW    = $clog2(QuotW);
  localparam logic [QuotW-1:0] RpmNum = 26'd60000000;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 26;

  localparam logic [CfgIdxW-1:0] RegMinInterval = 4'd0;
  localparam logic [CfgIdxW-1:0] RegMaxRpm      = 4'd1;
  localparam logic [CfgIdxW-1:0] RegTolerance   = 4'd2;
  localparam logic [CfgIdxW-1:0] RegAlpha       = 4'd3;
  localparam logic [CfgIdxW-1:0] RegLockCount   = 4'd4;
  localparam logic [CfgIdxW-1:0] RegLostTimeout = 4'd5;
  localparam logic [CfgIdxW-1:0] RegZeroTimeout = 4'd6;
  localparam logic [CfgIdxW-1:0] RegPulsesRev   = 4'd7;

  // Register values after reset.
  localparam logic [19:0] RstMinInterval = 20'd4000;
  localparam logic [15:0] RstMaxRpm      = 16'd15000;
  localparam logic [7:0]  RstTolerance   = 8'd64;
  localparam logic [8:0]  RstAlpha       = 9'd38;
  localparam logic [7:0]  RstLockCount   = 8'd5;
  localparam logic [25:0] RstLostTimeout = 26'd2000000;
  localparam logic [25:0] RstZeroTimeout = 26'd6000000;
  localparam logic [7:0]  RstPulsesRev   = 8'd1;

  // Current register contents.
  typedef struct packed {
    logic [19:0] min_interval;
    logic [15:0] max_rpm;
    logic [7:0]  tolerance;
    logic [8:0]  alpha;
    logic [7:0]  lock_count;
    logic [25:0] lost_timeout;
    logic [25:0] zero_timeout;
    logic [7:0]  pulses_rev;
  } cfg_t;

  // Commands from the controller to the datapath, at most one high per cycle.
  typedef struct packed {
    logic adv;          // request taken: latch edge, advance timers
    logic edge_eval;    // classify the edge and update counters
    logic div_load;     // form the divisor and start the division
    logic div_step;     // one quotient bit
    logic filt_mul;     // filter products
    logic filt_add;     // filter sum
    logic timeout_chk;  // lost and zero timeouts
    logic load_out;     // capture the result into the output register
  } cmd_t;

  // Status back to the controller.
  typedef struct packed {
    logic period_accept;  // valid during edge_eval: the period is accepted
  } sts_t;

endpackage

[sv/ptq_cfg.sv]
// Configuration register file of the pulse tachometer qualifier.
// Depends on ptq_pkg for the register indexes, reset values and cfg_t.
module ptq_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ptq_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ptq_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output ptq_pkg::cfg_t                 cfg_o
);

  ptq_pkg::cfg_t cfg_q, cfg_d;

  // Write decode; values are cut to the register width, unknown indexes are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        ptq_pkg::RegMinInterval: cfg_d.min_interval = cfg_wdata_i[19:0];
        ptq_pkg::RegMaxRpm:      cfg_d.max_rpm      = cfg_wdata_i[15:0];
        ptq_pkg::RegTolerance:   cfg_d.tolerance    = cfg_wdata_i[7:0];
        ptq_pkg::RegAlpha:       cfg_d.alpha        = cfg_wdata_i[8:0];
        ptq_pkg::RegLockCount:   cfg_d.lock_count   = cfg_wdata_i[7:0];
        ptq_pkg::RegLostTimeout: cfg_d.lost_timeout = cfg_wdata_i[25:0];
        ptq_pkg::RegZeroTimeout: cfg_d.zero_timeout = cfg_wdata_i[25:0];
        ptq_pkg::RegPulsesRev:   cfg_d.pulses_rev   = cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Register storage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_interval <= ptq_pkg::RstMinInterval;
      cfg_q.max_rpm      <= ptq_pkg::RstMaxRpm;
      cfg_q.tolerance    <= ptq_pkg::RstTolerance;
      cfg_q.alpha        <= ptq_pkg::RstAlpha;
      cfg_q.lock_count   <= ptq_pkg::RstLockCount;
      cfg_q.lost_timeout <= ptq_pkg::RstLostTimeout;
      cfg_q.zero_timeout <= ptq_pkg::RstZeroTimeout;
      cfg_q.pulses_rev   <= ptq_pkg::RstPulsesRev;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/ptq_ctrl.sv]
// Controller of the pulse tachometer qualifier: sequences one tick through the datapath.
// Depends on ptq_pkg for cmd_t, sts_t and the division length.
module ptq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  input  ptq_pkg::sts_t sts_i,
  output ptq_pkg::cmd_t cmd_o
);

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StEdge    = 3'd1;
  localparam logic [2:0] StDivLoad = 3'd2;
  localparam logic [2:0] StDiv     = 3'd3;
  localparam logic [2:0] StFiltMul = 3'd4;
  localparam logic [2:0] StFiltAdd = 3'd5;
  localparam logic [2:0] StTimeout = 3'd6;
  localparam logic [2:0] StOut     = 3'd7;

  logic [2:0]                    state_q, state_d;
  logic [ptq_pkg::DivCntW-1:0]   cnt_q, cnt_d;
  logic                          out_valid_q, out_valid_d;
  logic                          out_free;

  // The output register can take a result when empty or being drained.
  assign out_free = !out_valid_q || m_axis_tready;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          cmd_o.adv = 1'b1;
          state_d   = StEdge;
        end
      end
      StEdge: begin
        cmd_o.edge_eval = 1'b1;
        state_d = sts_i.period_accept ? StDivLoad : StTimeout;
      end
      StDivLoad: begin
        cmd_o.div_load = 1'b1;
        cnt_d   = '0;
        state_d = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == ptq_pkg::DivCntW'(ptq_pkg::QuotW - 1)) begin
          state_d = StFiltMul;
        end
      end
      StFiltMul: begin
        cmd_o.filt_mul = 1'b1;
        state_d = StFiltAdd;
      end
      StFiltAdd: begin
        cmd_o.filt_add = 1'b1;
        state_d = StTimeout;
      end
      StTimeout: begin
        cmd_o.timeout_chk = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Output valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;

endmodule

[sv/ptq_dp.sv]
// Datapath of the pulse tachometer qualifier: timers, counters, tolerance check,
// bit-serial rpm divider, exponential filter and the output register.
// Depends on ptq_pkg for cfg_t, cmd_t, sts_t and field widths.
module ptq_dp #(
  parameter int unsigned TIME_WIDTH  = ptq_pkg::TimeWidthDef,
  parameter int unsigned COUNT_WIDTH = ptq_pkg::CountWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ptq_pkg::cfg_t                cfg_i,
  input  ptq_pkg::cmd_t                cmd_i,
  output ptq_pkg::sts_t                sts_o,
  input  logic [ptq_pkg::STdataW-1:0]  s_axis_tdata,
  output logic [ptq_pkg::MTdataW-1:0]  m_axis_tdata
);

  localparam int unsigned TW   = TIME_WIDTH;
  localparam int unsigned CW   = COUNT_WIDTH;
  localparam int unsigned BW   = TW + 9;               // tolerance bound width
  localparam int unsigned DW   = TW + 8;               // divisor width
  localparam int unsigned QW   = ptq_pkg::QuotW;
  localparam int unsigned CMPW = (DW > QW + 1) ? DW : QW + 1;
  localparam int unsigned FW   = ptq_pkg::FiltW;
  localparam int unsigned PW   = FW + 9;               // filter product width

  // Measurement state.
  logic          edge_seen_q, once_q, lock_q, sig_q, edge_in_q;
  logic [TW-1:0] tse_q, tsa_q, last_period_q, good_q;
  logic [CW-1:0] acc_q, fast_q, outl_q;
  logic [QW-1:0] raw_q;
  logic [FW-1:0] filt_q;

  // Work registers.
  logic [BW-1:0] lo_q, hi_q;
  logic [DW-1:0] divisor_q;
  logic [QW-1:0] rem_q, quo_q;
  logic [PW-1:0] p1_q, p2_q;

  // Output register payload.
  logic [ptq_pkg::RpmW-1:0]    out_rpm_q;
  logic [FW-1:0]               out_filt_q;
  logic [ptq_pkg::PeriodW-1:0] out_period_q;
  logic                        out_sig_q, out_lock_q;
  logic [ptq_pkg::CountW-1:0]  out_acc_q, out_fast_q, out_outl_q;

  logic [TW-1:0] tse_inc, tsa_inc;
  logic [CW-1:0] acc_inc, fast_inc, outl_inc;
  logic [8:0]    alpha_eff, ppr_eff, tol_lo, tol_hi;
  logic [BW-1:0] period_x256;
  logic          in_tol, too_fast, accept_now;
  logic [QW:0]   rem_sh;
  logic [CMPW-1:0] rem_cmp, div_cmp;
  logic          q_bit;
  logic [15:0]   rpm16;
  logic          rpm_ok;
  logic [PW:0]   filt_sum;
  logic [31:0]   period_ext, acc_ext, fast_ext, outl_ext;

  // Saturating increments.
  assign tse_inc  = (&tse_q)  ? tse_q  : tse_q  + TW'(1);
  assign tsa_inc  = (&tsa_q)  ? tsa_q  : tsa_q  + TW'(1);
  assign acc_inc  = (&acc_q)  ? acc_q  : acc_q  + CW'(1);
  assign fast_inc = (&fast_q) ? fast_q : fast_q + CW'(1);
  assign outl_inc = (&outl_q) ? outl_q : outl_q + CW'(1);

  // Register values as used: alpha above one clamps, zero pulses per rev counts as one.
  assign alpha_eff = (cfg_i.alpha > 9'd256) ? 9'd256 : cfg_i.alpha;
  assign ppr_eff   = (cfg_i.pulses_rev == 8'd0) ? 9'd1 : {1'b0, cfg_i.pulses_rev};
  assign tol_lo    = 9'd256 - {1'b0, cfg_i.tolerance};
  assign tol_hi    = 9'd256 + {1'b0, cfg_i.tolerance};

  // Edge classification against the registered timer and tolerance bounds.
  assign period_x256 = BW'({tse_q, 8'd0});
  assign in_tol      = (period_x256 >= lo_q) && (period_x256 <= hi_q);
  assign too_fast    = 32'(tse_q) < 32'(cfg_i.min_interval);
  assign accept_now  = edge_in_q && edge_seen_q && !too_fast &&
                       ((32'(acc_q) < 32'(cfg_i.lock_count)) || (good_q == '0) || in_tol);
  assign sts_o.period_accept = accept_now;

  // One restoring division step.
  assign rem_sh  = {rem_q, quo_q[QW-1]};
  assign rem_cmp = CMPW'(rem_sh);
  assign div_cmp = CMPW'(divisor_q);
  assign q_bit   = rem_cmp >= div_cmp;

  // Filter input; only used when the rpm fits under the limit.
  assign rpm16    = quo_q[15:0];
  assign rpm_ok   = 32'(quo_q) <= 32'(cfg_i.max_rpm);
  assign filt_sum = (PW+1)'(p1_q) + (PW+1)'(p2_q) + (PW+1)'(128);

  // Output field extension.
  assign period_ext = 32'(last_period_q);
  assign acc_ext    = 32'(acc_q);
  assign fast_ext   = 32'(fast_q);
  assign outl_ext   = 32'(outl_q);

  // Measurement state, updated by one command per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_seen_q   <= 1'b0;
      once_q        <= 1'b0;
      lock_q        <= 1'b0;
      sig_q         <= 1'b0;
      edge_in_q     <= 1'b0;
      tse_q         <= '0;
      tsa_q         <= '0;
      last_period_q <= '0;
      good_q        <= '0;
      acc_q         <= '0;
      fast_q        <= '0;
      outl_q        <= '0;
      raw_q         <= '0;
      filt_q        <= '0;
    end else begin
      if (cmd_i.adv) begin
        edge_in_q <= s_axis_tdata[0];
        if (edge_seen_q) begin
          tse_q <= tse_inc;
        end
        if (once_q) begin
          tsa_q <= tsa_inc;
        end
      end
      if (cmd_i.edge_eval && edge_in_q) begin
        if (!edge_seen_q) begin
          edge_seen_q <= 1'b1;
          tse_q       <= '0;
        end else if (too_fast) begin
          fast_q <= fast_inc;
        end else begin
          last_period_q <= tse_q;
          tse_q         <= '0;
          if (accept_now) begin
            good_q <= tse_q;
            acc_q  <= acc_inc;
            once_q <= 1'b1;
            tsa_q  <= '0;
            sig_q  <= 1'b1;
            if (32'(acc_inc) >= 32'(cfg_i.lock_count)) begin
              lock_q <= 1'b1;
            end
          end else begin
            outl_q <= outl_inc;
          end
        end
      end
      if (cmd_i.filt_mul) begin
        raw_q <= quo_q;
      end
      if (cmd_i.filt_add && rpm_ok) begin
        if (filt_q == '0) begin
          filt_q <= {rpm16, 8'd0};
        end else begin
          filt_q <= filt_sum[FW+7:8];
        end
      end
      if (cmd_i.timeout_chk) begin
        if (once_q) begin
          // Zero timeout: everything but the registers goes back to reset.
          if (32'(tsa_q) > 32'(cfg_i.zero_timeout)) begin
            edge_seen_q   <= 1'b0;
            once_q        <= 1'b0;
            lock_q        <= 1'b0;
            sig_q         <= 1'b0;
            tse_q         <= '0;
            tsa_q         <= '0;
            last_period_q <= '0;
            good_q        <= '0;
            acc_q         <= '0;
            fast_q        <= '0;
            outl_q        <= '0;
            raw_q         <= '0;
            filt_q        <= '0;
          end else if (32'(tsa_q) > 32'(cfg_i.lost_timeout)) begin
            sig_q <= 1'b0;
          end
        end else begin
          raw_q  <= '0;
          filt_q <= '0;
          sig_q  <= 1'b0;
        end
      end
    end
  end

  // Tolerance bounds, divider and filter products.
  always_ff @(posedge clk_i) begin
    if (cmd_i.adv) begin
      lo_q <= BW'(good_q) * BW'(tol_lo);
      hi_q <= BW'(good_q) * BW'(tol_hi);
    end
    if (cmd_i.div_load) begin
      divisor_q <= DW'(last_period_q) * DW'(ppr_eff);
      rem_q     <= '0;
      quo_q     <= ptq_pkg::RpmNum;
    end
    if (cmd_i.div_step) begin
      rem_q <= q_bit ? QW'(rem_cmp - div_cmp) : rem_sh[QW-1:0];
      quo_q <= {quo_q[QW-2:0], q_bit};
    end
    if (cmd_i.filt_mul) begin
      p1_q <= PW'(alpha_eff) * PW'({rpm16, 8'd0});
      p2_q <= PW'(9'd256 - alpha_eff) * PW'(filt_q);
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_rpm_q    <= raw_q;
      out_filt_q   <= filt_q;
      out_period_q <= period_ext[ptq_pkg::PeriodW-1:0];
      out_sig_q    <= sig_q;
      out_lock_q   <= lock_q;
      out_acc_q    <= acc_ext[ptq_pkg::CountW-1:0];
      out_fast_q   <= fast_ext[ptq_pkg::CountW-1:0];
      out_outl_q   <= outl_ext[ptq_pkg::CountW-1:0];
    end
  end

  assign m_axis_tdata = {2'b00, out_outl_q, out_fast_q, out_acc_q, out_lock_q, out_sig_q,
                         out_period_q, out_filt_q, out_rpm_q};

endmodule

[sv/pulse_tachometer_qualifier.sv]
// Top level of the pulse tachometer qualifier.
// Depends on ptq_pkg, ptq_cfg, ptq_ctrl and ptq_dp.
//
// One request on the slave stream is one microsecond tick; bit 0 of its data says
// whether a falling sensor edge came in that tick. Every tick gives exactly one
// result on the master stream: raw rpm, filtered rpm, period, status flags and
// the pulse, fast-reject and outlier counters.
// Registers must be written through cfg_we_i, cfg_index_i and cfg_wdata_i while no
// tick is in flight, which the block does not enforce; unknown indexes are ignored.
// A tick without an accepted period goes from edge evaluation to the timeout check
// and the output load. A tick that accepts a period also passes through a restoring
// divider that produces one of its 26 quotient bits per cycle, followed by the
// filter multiply and add steps. One tick is in flight at a time.
// The result sits in an output register, so the next tick is taken while it waits;
// if the receiver stalls, the following result waits in the sequencer and no
// further tick is accepted until the register drains.
// Reset loads the register defaults and clears all measurement state.
module pulse_tachometer_qualifier #(
  parameter int unsigned TIME_WIDTH  = ptq_pkg::TimeWidthDef,
  parameter int unsigned COUNT_WIDTH = ptq_pkg::CountWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [0] edge_req, [7:1] zero
  input  logic [ptq_pkg::STdataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [25:0] rpm_raw, [49:26] rpm_filtered_q8, [75:50] period_us, [76] signal_ok,
  // [77] locked, [93:78] accepted_count, [109:94] fast_reject_count,
  // [125:110] outlier_count, [127:126] zero
  output logic [ptq_pkg::MTdataW-1:0]   m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [ptq_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ptq_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  ptq_pkg::cfg_t cfg;
  ptq_pkg::cmd_t cmd;
  ptq_pkg::sts_t sts;

  // Register file.
  ptq_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Sequencer.
  ptq_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  // Measurement datapath.
  ptq_dp #(
    .TIME_WIDTH  (TIME_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tdata (m_axis_tdata)
  );

endmodule

[tb/pulse_tachometer_qualifier_tb.sv]
// Self-checking testbench for the pulse tachometer qualifier: tick requests in, results out.
// Predicts results with its model of timers, filter and counters; directed rows may fix them.
// Depends on ptq_pkg and pulse_tachometer_qualifier.
module pulse_tachometer_qualifier_tb;

  localparam int unsigned ClkHalf       = 5;
  localparam int unsigned ResetCycles   = 4;
  // Long enough to cover any tick in flight, including one that accepts a period.
  localparam int unsigned SettleCycles  = 40;
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned RegCount      = 8;
  localparam int unsigned DirRows       = 24;
  localparam int unsigned PhaseCount    = 10;
  localparam int unsigned SilenceCap    = 300;
  localparam logic [ptq_pkg::PeriodW-1:0] TimeMax = '1;
  localparam logic [ptq_pkg::CountW-1:0]  CountMax = '1;
  localparam longint unsigned RpmNumerator = 60000000;
  localparam int RegWidth [RegCount] = '{20, 16, 8, 9, 8, 26, 26, 8};

  typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  // One result, laid out as on the master data bus, lowest field last.
  typedef struct packed {
    logic [1:0]                  pad;
    logic [ptq_pkg::CountW-1:0]  outliers;
    logic [ptq_pkg::CountW-1:0]  fast_rejects;
    logic [ptq_pkg::CountW-1:0]  accepted;
    logic                        locked;
    logic                        signal_ok;
    logic [ptq_pkg::PeriodW-1:0] period;
    logic [ptq_pkg::FiltW-1:0]   filtered;
    logic [ptq_pkg::RpmW-1:0]    raw;
  } tach_out_t;

  typedef struct packed {
    logic      edge_in;
    logic      typed;
    tach_out_t want;
  } dir_row_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [ptq_pkg::STdataW-1:0]  s_axis_tdata = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [ptq_pkg::MTdataW-1:0]  m_axis_tdata;
  logic                         cfg_we_i = 1'b0;
  logic [ptq_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [ptq_pkg::CfgDataW-1:0] cfg_wdata_i = '0;

  pulse_tachometer_qualifier dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Predicted measurement state and register contents.
  ptq_pkg::cfg_t               tk_cfg;
  logic                        tk_edge_seen;
  logic [ptq_pkg::PeriodW-1:0] tk_since_edge;
  logic [ptq_pkg::PeriodW-1:0] tk_last_period;
  logic [ptq_pkg::PeriodW-1:0] tk_good_period;
  logic [ptq_pkg::CountW-1:0]  tk_accepted;
  logic                        tk_accepted_once;
  logic [ptq_pkg::PeriodW-1:0] tk_since_accept;
  logic                        tk_locked;
  logic                        tk_signal_ok;
  logic [ptq_pkg::RpmW-1:0]    tk_rpm_raw;
  logic [ptq_pkg::FiltW-1:0]   tk_rpm_filt;
  logic [ptq_pkg::CountW-1:0]  tk_fast_rejects;
  logic [ptq_pkg::CountW-1:0]  tk_outliers;

  tach_out_t  tach_expect_q [$];
  idle_mode_e idle_mode = IdleNone;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned quiet_cycles = 0;

  // Pulse train shaping for the random phases.
  int gap_left;
  int nominal_gap;
  int gap_jitter;
  int noise_pct;
  int silence_gap;

  dir_row_t dir_tab [DirRows];

  // Clock generator.
  initial begin
    forever #(ClkHalf) clk_i = ~clk_i;
  end

  function automatic logic [ptq_pkg::PeriodW-1:0] sat_time(
    input logic [ptq_pkg::PeriodW-1:0] v);
    return (v == TimeMax) ? v : v + 1'b1;
  endfunction

  function automatic logic [ptq_pkg::CountW-1:0] sat_count(
    input logic [ptq_pkg::CountW-1:0] v);
    return (v == CountMax) ? v : v + 1'b1;
  endfunction

  function automatic void tach_clear();
    tk_edge_seen     = 1'b0;
    tk_since_edge    = '0;
    tk_last_period   = '0;
    tk_good_period   = '0;
    tk_accepted      = '0;
    tk_accepted_once = 1'b0;
    tk_since_accept  = '0;
    tk_locked        = 1'b0;
    tk_signal_ok     = 1'b0;
    tk_rpm_raw       = '0;
    tk_rpm_filt      = '0;
    tk_fast_rejects  = '0;
    tk_outliers      = '0;
  endfunction

  // Register writes keep only the bits that fit; unknown indexes change nothing.
  function automatic void tach_store_reg(input logic [ptq_pkg::CfgIdxW-1:0] idx,
                                         input logic [ptq_pkg::CfgDataW-1:0] data);
    case (idx)
      ptq_pkg::RegMinInterval: tk_cfg.min_interval = data[19:0];
      ptq_pkg::RegMaxRpm:      tk_cfg.max_rpm      = data[15:0];
      ptq_pkg::RegTolerance:   tk_cfg.tolerance    = data[7:0];
      ptq_pkg::RegAlpha:       tk_cfg.alpha        = data[8:0];
      ptq_pkg::RegLockCount:   tk_cfg.lock_count   = data[7:0];
      ptq_pkg::RegLostTimeout: tk_cfg.lost_timeout = data[25:0];
      ptq_pkg::RegZeroTimeout: tk_cfg.zero_timeout = data[25:0];
      ptq_pkg::RegPulsesRev:   tk_cfg.pulses_rev   = data[7:0];
      default: ;
    endcase
  endfunction

  // Advances the model by one microsecond tick and returns the result it shows.
  function automatic tach_out_t tach_predict(input logic edge_in);
    tach_out_t res;
    longint unsigned period;
    longint unsigned good;
    longint unsigned tol;
    longint unsigned ppr;
    longint unsigned alpha;
    longint unsigned rpm;
    longint unsigned filt;
    bit in_band;
    if (tk_edge_seen) tk_since_edge = sat_time(tk_since_edge);
    if (tk_accepted_once) tk_since_accept = sat_time(tk_since_accept);

    if (edge_in) begin
      if (!tk_edge_seen) begin
        tk_edge_seen  = 1'b1;
        tk_since_edge = '0;
      end else if (tk_since_edge < tk_cfg.min_interval) begin
        tk_fast_rejects = sat_count(tk_fast_rejects);
      end else begin
        period         = tk_since_edge;
        tk_last_period = tk_since_edge;
        tk_since_edge  = '0;
        good = tk_good_period;
        tol  = tk_cfg.tolerance;
        in_band = (good == 0) ||
                  ((period * 256 >= good * (256 - tol)) && (period * 256 <= good * (256 + tol)));
        if ((tk_accepted < tk_cfg.lock_count) || in_band) begin
          ppr   = (tk_cfg.pulses_rev == 0) ? 1 : tk_cfg.pulses_rev;
          alpha = (tk_cfg.alpha > 256) ? 256 : tk_cfg.alpha;
          tk_good_period   = period[ptq_pkg::PeriodW-1:0];
          tk_accepted      = sat_count(tk_accepted);
          tk_accepted_once = 1'b1;
          tk_since_accept  = '0;
          tk_signal_ok     = 1'b1;
          if (tk_accepted >= tk_cfg.lock_count) tk_locked = 1'b1;
          rpm        = RpmNumerator / (period * ppr);
          tk_rpm_raw = rpm[ptq_pkg::RpmW-1:0];
          // The filter is seeded by the first rpm that is within the limit.
          if (rpm <= tk_cfg.max_rpm) begin
            if (tk_rpm_filt == 0) begin
              filt = rpm << 8;
            end else begin
              filt = (alpha * (rpm << 8) + (256 - alpha) * tk_rpm_filt + 128) >> 8;
            end
            tk_rpm_filt = filt[ptq_pkg::FiltW-1:0];
          end
        end else begin
          tk_outliers = sat_count(tk_outliers);
        end
      end
    end

    // Timeouts run only once a pulse has been accepted.
    if (tk_accepted_once) begin
      if (tk_since_accept > tk_cfg.lost_timeout) tk_signal_ok = 1'b0;
      if (tk_since_accept > tk_cfg.zero_timeout) tach_clear();
    end else begin
      tk_rpm_raw   = '0;
      tk_rpm_filt  = '0;
      tk_signal_ok = 1'b0;
    end

    res              = '0;
    res.raw          = tk_rpm_raw;
    res.filtered     = tk_rpm_filt;
    res.period       = tk_last_period;
    res.signal_ok    = tk_signal_ok;
    res.locked       = tk_locked;
    res.accepted     = tk_accepted;
    res.fast_rejects = tk_fast_rejects;
    res.outliers     = tk_outliers;
    return res;
  endfunction

  function automatic tach_out_t tach_fields(
    input longint unsigned raw, input longint unsigned filtered,
    input longint unsigned period, input bit signal_ok, input bit locked,
    input longint unsigned accepted, input longint unsigned fast_rejects,
    input longint unsigned outliers);
    tach_out_t res;
    res              = '0;
    res.raw          = raw[ptq_pkg::RpmW-1:0];
    res.filtered     = filtered[ptq_pkg::FiltW-1:0];
    res.period       = period[ptq_pkg::PeriodW-1:0];
    res.signal_ok    = signal_ok;
    res.locked       = locked;
    res.accepted     = accepted[ptq_pkg::CountW-1:0];
    res.fast_rejects = fast_rejects[ptq_pkg::CountW-1:0];
    res.outliers     = outliers[ptq_pkg::CountW-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] result %0d: %s", $realtime, results_seen, what);
    mismatches++;
  endtask

  function automatic bit sender_pause();
    case (idle_mode)
      IdleSender: return $urandom_range(0, 99) < 80;
      IdleBoth:   return $urandom_range(0, 99) < 16;
      default:    return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (idle_mode)
      IdleReceiver: return $urandom_range(0, 99) < 80;
      IdleBoth:     return $urandom_range(0, 99) < 16;
      default:      return 1'b0;
    endcase
  endfunction

  // Regular pulses with jitter, missed pulses, stray edges and long silences.
  function automatic logic next_edge();
    int r;
    int gap;
    gap_left--;
    if (gap_left <= 0) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        gap = nominal_gap - gap_jitter + $urandom_range(0, 2 * gap_jitter);
      end else if (r < 93) begin
        gap = 2 * nominal_gap;
      end else begin
        gap = silence_gap + $urandom_range(1, 3);
      end
      gap_left = (gap < 1) ? 1 : gap;
      return 1'b1;
    end
    return $urandom_range(0, 99) < noise_pct;
  endfunction

  // Register write, sometimes with junk above the register width.
  task automatic write_reg(input logic [ptq_pkg::CfgIdxW-1:0] idx,
                           input logic [ptq_pkg::CfgDataW-1:0] val);
    logic [ptq_pkg::CfgDataW-1:0] junk;
    int unsigned w;
    w    = (idx < RegCount) ? RegWidth[idx] : ptq_pkg::CfgDataW;
    junk = $urandom_range(0, 1) ? (ptq_pkg::CfgDataW'($urandom) << w) : '0;
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val | junk;
    tach_store_reg(idx, val | junk);
  endtask

  task automatic apply_settings(input ptq_pkg::cfg_t c);
    write_reg(ptq_pkg::RegMinInterval, ptq_pkg::CfgDataW'(c.min_interval));
    write_reg(ptq_pkg::RegMaxRpm,      ptq_pkg::CfgDataW'(c.max_rpm));
    write_reg(ptq_pkg::RegTolerance,   ptq_pkg::CfgDataW'(c.tolerance));
    write_reg(ptq_pkg::RegAlpha,       ptq_pkg::CfgDataW'(c.alpha));
    write_reg(ptq_pkg::RegLockCount,   ptq_pkg::CfgDataW'(c.lock_count));
    write_reg(ptq_pkg::RegLostTimeout, ptq_pkg::CfgDataW'(c.lost_timeout));
    write_reg(ptq_pkg::RegZeroTimeout, ptq_pkg::CfgDataW'(c.zero_timeout));
    write_reg(ptq_pkg::RegPulsesRev,   ptq_pkg::CfgDataW'(c.pulses_rev));
    // An index past the register file must leave everything alone.
    write_reg(ptq_pkg::CfgIdxW'($urandom_range(RegCount, (1 << ptq_pkg::CfgIdxW) - 1)),
              ptq_pkg::CfgDataW'($urandom));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One tick request; the expectation is queued at the edge that takes it.
  task automatic send_tick(input logic edge_in, input bit hold, input bit typed,
                           input tach_out_t typed_val);
    tach_out_t predicted;
    @(negedge clk_i);
    while ((hold && tach_expect_q.size() != 0) || sender_pause()) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ptq_pkg::STdataW'(edge_in);
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = tach_predict(edge_in);
    tach_expect_q.push_back(typed ? typed_val : predicted);
  endtask

  // Waits until every expected result has come and the block has gone quiet.
  task automatic drain_and_settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (tach_expect_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Receiver side: tready changes on the falling edge.
  initial begin
    forever begin
      @(negedge clk_i);
      m_axis_tready <= !receiver_stall();
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin : result_monitor
    tach_out_t got;
    tach_out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = tach_out_t'(m_axis_tdata);
      if (tach_expect_q.size() == 0) begin
        report_mismatch("result with no tick waiting for it");
      end else begin
        want = tach_expect_q.pop_front();
        if (got.raw != want.raw)
          report_mismatch($sformatf("rpm_raw %0d, expected %0d", got.raw, want.raw));
        if (got.filtered != want.filtered)
          report_mismatch($sformatf("rpm_filtered_q8 %0d, expected %0d",
                                    got.filtered, want.filtered));
        if (got.period != want.period)
          report_mismatch($sformatf("period_us %0d, expected %0d", got.period, want.period));
        if (got.signal_ok != want.signal_ok)
          report_mismatch($sformatf("signal_ok %0b, expected %0b",
                                    got.signal_ok, want.signal_ok));
        if (got.locked != want.locked)
          report_mismatch($sformatf("locked %0b, expected %0b", got.locked, want.locked));
        if (got.accepted != want.accepted)
          report_mismatch($sformatf("accepted_count %0d, expected %0d",
                                    got.accepted, want.accepted));
        if (got.fast_rejects != want.fast_rejects)
          report_mismatch($sformatf("fast_reject_count %0d, expected %0d",
                                    got.fast_rejects, want.fast_rejects));
        if (got.outliers != want.outliers)
          report_mismatch($sformatf("outlier_count %0d, expected %0d",
                                    got.outliers, want.outliers));
      end
      results_seen++;
    end
  end

  // Watchdog: ends the run when neither stream moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Main sequence: reset, directed ticks, then random phases under varied settings.
  initial begin : stimulus
    ptq_pkg::cfg_t setting;
    int   items;
    longint unsigned longest;
    tk_cfg = '{ptq_pkg::RstMinInterval, ptq_pkg::RstMaxRpm, ptq_pkg::RstTolerance,
               ptq_pkg::RstAlpha, ptq_pkg::RstLockCount, ptq_pkg::RstLostTimeout,
               ptq_pkg::RstZeroTimeout, ptq_pkg::RstPulsesRev};
    tach_clear();

    // Directed ticks: fast reject, first accept at exactly the rpm limit (largest
    // filtered value), an outlier with zero tolerance, loss of signal, full clear.
    dir_tab = '{
      '{1'b0, 1'b1, '0},
      '{1'b1, 1'b1, '0},
      '{1'b1, 1'b1, tach_fields(0, 0, 0, 0, 0, 0, 1, 0)},
      '{1'b0, 1'b0, '0},
      '{1'b0, 1'b0, '0},
      '{1'b1, 1'b1, tach_fields(60000, 15360000, 4, 1, 1, 1, 1, 0)},
      '{1'b0, 1'b0, '0},
      '{1'b0, 1'b0, '0},
      '{1'b0, 1'b0, '0},
      '{1'b0, 1'b0, '0},
      '{1'b1, 1'b1, tach_fields(60000, 15360000, 5, 1, 1, 1, 1, 1)},
      '{1'b0, 1'b0, '0},
      '{1'b0, 1'b1, tach_fields(60000, 15360000, 5, 0, 1, 1, 1, 1)},
      '{1'b0, 1'b0, '0},
      '{1'b0, 1'b0, '0},
      '{1'b0, 1'b0, '0},
      '{1'b0, 1'b0, '0},
      '{1'b0, 1'b0, '0},
      '{1'b0, 1'b1, '0},
      '{1'b1, 1'b0, '0},
      '{1'b0, 1'b0, '0},
      '{1'b0, 1'b0, '0},
      '{1'b0, 1'b0, '0},
      '{1'b1, 1'b1, tach_fields(60000, 15360000, 4, 1, 1, 1, 0, 0)}
    };

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    setting.min_interval = 20'd4;
    setting.max_rpm      = 16'd60000;
    setting.tolerance    = 8'd0;
    setting.alpha        = 9'd256;
    setting.lock_count   = 8'd1;
    setting.lost_timeout = 26'd6;
    setting.zero_timeout = 26'd12;
    setting.pulses_rev   = 8'd250;
    apply_settings(setting);
    for (int i = 0; i < DirRows; i++) begin
      send_tick(dir_tab[i].edge_in, 1'b0, dir_tab[i].typed, dir_tab[i].want);
    end
    drain_and_settle();

    // Random phases; the early ones pin registers to their extremes, the
    // next-to-last restores the reset values and the last has the longest minimum interval.
    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        1:       setting.min_interval = 20'd1;
        8:       setting.min_interval = ptq_pkg::RstMinInterval;
        9:       setting.min_interval = 20'd1000000;
        default: setting.min_interval = 20'($urandom_range(2, 10));
      endcase
      nominal_gap = (setting.min_interval > 64) ? 40
                  : setting.min_interval + $urandom_range(0, 12);
      gap_jitter  = 1 + nominal_gap / 4;
      noise_pct   = 3;
      gap_left    = 1;

      case (p)
        0:       setting.max_rpm = 16'd60000;
        1:       setting.max_rpm = 16'd1;
        8:       setting.max_rpm = ptq_pkg::RstMaxRpm;
        default: setting.max_rpm = 16'($urandom_range(1, 60000));
      endcase
      case (p)
        0:       setting.tolerance = 8'd0;
        1:       setting.tolerance = 8'd255;
        8:       setting.tolerance = ptq_pkg::RstTolerance;
        default: setting.tolerance = 8'($urandom_range(0, 255));
      endcase
      // Alpha of zero holds the filter; anything above 256 acts as 256.
      case (p)
        0:       setting.alpha = 9'd256;
        1:       setting.alpha = 9'd1;
        2:       setting.alpha = 9'd0;
        3:       setting.alpha = 9'd511;
        8:       setting.alpha = ptq_pkg::RstAlpha;
        default: setting.alpha = 9'($urandom_range(1, 256));
      endcase
      // Lock count of zero checks every period against the tolerance.
      case (p)
        0:       setting.lock_count = 8'd1;
        1:       setting.lock_count = 8'd255;
        2:       setting.lock_count = 8'd0;
        8:       setting.lock_count = ptq_pkg::RstLockCount;
        default: setting.lock_count = 8'($urandom_range(1, 8));
      endcase
      // Zero pulses per revolution counts as one.
      case (p)
        0:       setting.pulses_rev = 8'd255;
        1:       setting.pulses_rev = 8'd0;
        2:       setting.pulses_rev = 8'd1;
        8:       setting.pulses_rev = ptq_pkg::RstPulsesRev;
        default: setting.pulses_rev = 8'($urandom_range(64, 255));
      endcase
      case (p)
        1:       setting.lost_timeout = 26'd1;
        3:       setting.lost_timeout = TimeMax;
        8:       setting.lost_timeout = ptq_pkg::RstLostTimeout;
        default: setting.lost_timeout = 26'(nominal_gap * $urandom_range(2, 5));
      endcase
      // A zero timeout at the timer maximum can never fire.
      case (p)
        1:       setting.zero_timeout = TimeMax;
        2:       setting.zero_timeout = 26'd1;
        8:       setting.zero_timeout = ptq_pkg::RstZeroTimeout;
        default: setting.zero_timeout =
                   26'(setting.lost_timeout + nominal_gap * $urandom_range(1, 4));
      endcase
      longest = $urandom_range(0, 1) ? setting.lost_timeout : setting.zero_timeout;
      silence_gap = (longest > SilenceCap) ? SilenceCap : int'(longest);

      apply_settings(setting);
      idle_mode = idle_mode_e'(p % 4);
      items = (p < 8) ? 105 : ((p == 8) ? 60 : 30);
      for (int n = 0; n < items; n++) begin
        send_tick(next_edge(), (p == 0 && n == 50) || ($urandom_range(0, 39) == 0),
                  1'b0, '0);
      end
      drain_and_settle();
    end

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
